/* rtl/splm_pkg.sv */
`timescale 1ns / 1ps

package splm_pkg;

	localparam int SLOTS_DEF = 16;
	localparam logic [20:0] CAP_RESET = 21'd4096;

	localparam logic [2:0] K_TAKE_FREE  = 3'd0;
	localparam logic [2:0] K_TAKE_READY = 3'd1;
	localparam logic [2:0] K_PUBLISH    = 3'd2;
	localparam logic [2:0] K_CONSUME    = 3'd3;
	localparam logic [2:0] K_REL_FILL   = 3'd4;
	localparam logic [2:0] K_REL_READY  = 3'd5;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NONE    = 3'd1;
	localparam logic [2:0] ST_WRONG   = 3'd2;
	localparam logic [2:0] ST_CAP     = 3'd3;
	localparam logic [2:0] ST_RELEASE = 3'd4;

	typedef enum logic [1:0] {
		PH_FREE    = 2'd0,
		PH_FILLING = 2'd1,
		PH_READY   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  slot;
		logic [20:0] byte_count;
	} request_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  granted_slot;
		logic [20:0] payload_bytes;
		logic [4:0]  free_count;
		logic [4:0]  filling_count;
		logic [4:0]  ready_count;
	} result_t;

	typedef struct packed {
		logic init_step;
		logic accept;
		logic lookup;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic init_last;
	} dp_status_t;

endpackage

/* rtl/slot_pool_lease_manager.sv */
`timescale 1ns / 1ps
// Slot pool lease manager: hands out buffer slots to a producer and a consumer.
// request channel (valid/ready): kind, slot and byte_count of one request item.
// result channel (valid/ready): exactly one result item per request, in order,
//   with status, granted slot, payload bytes and the per-phase slot counts.
// cfg_wr_en/cfg_wr_data: writes the slot capacity; write only while idle.
// The free/ready queue heads are read at the accepting edge, the payload store
//   in the LOOK state, and the result is committed in the COMMIT state once the
//   output register is free. The next request is accepted the cycle after
//   commit: a new request is not taken until the last one is committed, a bound
//   set by the two dependent memory reads and the commit.
// Reset: all slots free, free queue loaded 0..SLOTS-1 by a sweep during which
//   request_ready stays low; capacity resets to 4096.
// The result is held in an output register; if the receiver stalls, a new
//   request is still accepted and processed up to commit, which waits until
//   the held result is taken.
module slot_pool_lease_manager
	import splm_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [20:0] cfg_wr_data,
	input  logic        request_valid,
	output logic        request_ready,
	input  request_t    request,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result
);

	cmd_t       cmd;
	dp_status_t dp_st;

	splm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_ready (request_ready),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.dp_st         (dp_st),
		.cmd           (cmd)
	);

	splm_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.request     (request),
		.cmd         (cmd),
		.dp_st       (dp_st),
		.result      (result)
	);

endmodule

/* rtl/splm_ctrl.sv */
`timescale 1ns / 1ps

module splm_ctrl
	import splm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       request_valid,
	output logic       request_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  dp_status_t dp_st,
	output cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_INIT   = 4'b0001,
		S_IDLE   = 4'b0010,
		S_LOOK   = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   result_valid_q;
	logic   out_free;

	assign out_free      = !result_valid_q || result_ready;
	assign request_ready = (state_q == S_IDLE);
	assign result_valid  = result_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (dp_st.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (request_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = S_COMMIT;
			end
			S_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_INIT;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/splm_dp.sv */
`timescale 1ns / 1ps

module splm_dp
	import splm_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [20:0] cfg_wr_data,
	input  request_t    request,
	input  cmd_t        cmd,
	output dp_status_t  dp_st,
	output result_t     result
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
		return (32'(v) == SLOTS - 1) ? '0 : v + 1'b1;
	endfunction

	logic [IW-1:0] free_mem [SLOTS];
	logic [IW-1:0] ready_mem [SLOTS];
	logic [20:0]   pay_mem [SLOTS];

	phase_t        phase_q [SLOTS];
	logic          leased_q [SLOTS];
	logic [20:0]   cap_q;
	request_t      item_q;
	result_t       result_q;
	logic [IW-1:0] init_idx_q;
	logic [IW-1:0] free_head_q, free_tail_q, ready_head_q, ready_tail_q;
	logic [CW-1:0] free_cnt_q, ready_q_cnt_q, nfill_q, nready_q;
	logic [IW-1:0] free_rd_q, ready_rd_q;
	logic [20:0]   pay_rd_q;

	logic          in_range, lease_fill, lease_ready;
	logic [IW-1:0] sidx;
	logic [2:0]    status;
	logic [IW-1:0] granted;
	logic [20:0]   pay_out;
	logic          wr_en, wr_leased, pay_we;
	logic [IW-1:0] wr_idx;
	phase_t        wr_phase;
	logic          pop_free, pop_ready, push_free, push_ready;
	logic          push_free_g, push_ready_g;
	logic          fill_inc, fill_dec, ready_inc, ready_dec;
	logic [CW-1:0] free_cnt_d, ready_q_cnt_d, nfill_d, nready_d;

	assign dp_st.init_last = (32'(init_idx_q) == SLOTS - 1);
	assign result          = result_q;

	assign sidx        = IW'(item_q.slot);
	assign in_range    = (32'(item_q.slot) < SLOTS);
	assign lease_fill  = in_range && (phase_q[sidx] == PH_FILLING) && leased_q[sidx];
	assign lease_ready = in_range && (phase_q[sidx] == PH_READY) && leased_q[sidx];

	always_comb begin
		status     = ST_OK;
		granted    = '0;
		pay_out    = '0;
		wr_en      = 1'b0;
		wr_idx     = sidx;
		wr_phase   = PH_FREE;
		wr_leased  = 1'b0;
		pay_we     = 1'b0;
		pop_free   = 1'b0;
		pop_ready  = 1'b0;
		push_free  = 1'b0;
		push_ready = 1'b0;
		fill_inc   = 1'b0;
		fill_dec   = 1'b0;
		ready_inc  = 1'b0;
		ready_dec  = 1'b0;
		case (item_q.kind)
			K_TAKE_FREE: begin
				if (free_cnt_q == '0) begin
					status = ST_NONE;
				end else begin
					pop_free  = 1'b1;
					wr_en     = 1'b1;
					wr_idx    = free_rd_q;
					wr_phase  = PH_FILLING;
					wr_leased = 1'b1;
					fill_inc  = 1'b1;
					granted   = free_rd_q;
					pay_out   = cap_q;
				end
			end
			K_TAKE_READY: begin
				if (ready_q_cnt_q == '0) begin
					status = ST_NONE;
				end else begin
					pop_ready = 1'b1;
					wr_en     = 1'b1;
					wr_idx    = ready_rd_q;
					wr_phase  = PH_READY;
					wr_leased = 1'b1;
					granted   = ready_rd_q;
					pay_out   = pay_rd_q;
				end
			end
			K_PUBLISH: begin
				if (!lease_fill) begin
					status = ST_WRONG;
				end else if (item_q.byte_count > cap_q) begin
					status = ST_CAP;
				end else begin
					pay_we     = 1'b1;
					wr_en      = 1'b1;
					wr_phase   = PH_READY;
					fill_dec   = 1'b1;
					ready_inc  = 1'b1;
					push_ready = 1'b1;
				end
			end
			K_CONSUME: begin
				if (!lease_ready) begin
					status = ST_WRONG;
				end else begin
					wr_en     = 1'b1;
					wr_phase  = PH_FREE;
					ready_dec = 1'b1;
					push_free = 1'b1;
				end
			end
			K_REL_FILL: begin
				if (!lease_fill) begin
					status = ST_RELEASE;
				end else begin
					wr_en     = 1'b1;
					wr_phase  = PH_FREE;
					fill_dec  = 1'b1;
					push_free = 1'b1;
				end
			end
			K_REL_READY: begin
				if (!lease_ready) begin
					status = ST_RELEASE;
				end else begin
					wr_en      = 1'b1;
					wr_phase   = PH_READY;
					push_ready = 1'b1;
				end
			end
			default: begin
				status = ST_RELEASE;
			end
		endcase
	end

	assign push_free_g  = push_free && (32'(free_cnt_q) < SLOTS);
	assign push_ready_g = push_ready && (32'(ready_q_cnt_q) < SLOTS);

	assign free_cnt_d    = free_cnt_q - CW'(pop_free) + CW'(push_free_g);
	assign ready_q_cnt_d = ready_q_cnt_q - CW'(pop_ready) + CW'(push_ready_g);
	assign nfill_d       = nfill_q + CW'(fill_inc) - CW'(fill_dec);
	assign nready_d      = nready_q + CW'(ready_inc) - CW'(ready_dec);

	// free queue: reset sweep loads slot indices in order
	always_ff @(posedge clk) begin
		if (cmd.init_step) begin
			free_mem[init_idx_q] <= init_idx_q;
		end else if (cmd.commit && push_free_g) begin
			free_mem[free_tail_q] <= sidx;
		end
		if (cmd.accept) begin
			free_rd_q <= free_mem[free_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && push_ready_g) begin
			ready_mem[ready_tail_q] <= sidx;
		end
		if (cmd.accept) begin
			ready_rd_q <= ready_mem[ready_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && pay_we) begin
			pay_mem[sidx] <= item_q.byte_count;
		end
		if (cmd.lookup) begin
			pay_rd_q <= pay_mem[ready_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= request;
		end
		if (cmd.commit) begin
			result_q.status        <= status;
			result_q.granted_slot  <= 4'(granted);
			result_q.payload_bytes <= pay_out;
			result_q.free_count    <= 5'(free_cnt_d);
			result_q.filling_count <= 5'(nfill_d);
			result_q.ready_count   <= 5'(nready_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				phase_q[i]  <= PH_FREE;
				leased_q[i] <= 1'b0;
			end
			cap_q         <= CAP_RESET;
			init_idx_q    <= '0;
			free_head_q   <= '0;
			free_tail_q   <= '0;
			ready_head_q  <= '0;
			ready_tail_q  <= '0;
			free_cnt_q    <= CW'(SLOTS);
			ready_q_cnt_q <= '0;
			nfill_q       <= '0;
			nready_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.init_step) begin
				init_idx_q <= wrap_inc(init_idx_q);
			end
			if (cmd.commit) begin
				if (wr_en) begin
					phase_q[wr_idx]  <= wr_phase;
					leased_q[wr_idx] <= wr_leased;
				end
				if (pop_free) begin
					free_head_q <= wrap_inc(free_head_q);
				end
				if (push_free_g) begin
					free_tail_q <= wrap_inc(free_tail_q);
				end
				if (pop_ready) begin
					ready_head_q <= wrap_inc(ready_head_q);
				end
				if (push_ready_g) begin
					ready_tail_q <= wrap_inc(ready_tail_q);
				end
				free_cnt_q    <= free_cnt_d;
				ready_q_cnt_q <= ready_q_cnt_d;
				nfill_q       <= nfill_d;
				nready_q      <= nready_d;
			end
		end
	end

endmodule

/* test/slot_pool_lease_checker.sv */
`timescale 1ns / 1ps

module slot_pool_lease_checker
	import splm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [20:0] cfg_wr_data,
	input  logic        request_valid,
	input  logic        request_ready,
	input  request_t    request,
	input  logic        result_valid,
	input  logic        result_ready,
	input  result_t     result,
	output int          mismatches,
	output int          pending,
	output int          results_checked
);

	localparam int POOL = SLOTS_DEF;

	logic [20:0] capacity;
	phase_t      pool_phase [POOL];
	logic        pool_leased [POOL];
	logic [20:0] pool_bytes [POOL];
	logic [3:0]  free_list [$];
	logic [3:0]  ready_list [$];
	result_t     expected_results [$];

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [20:0] got,
		input logic [20:0] want);
		if (got !== want)
			report($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	function automatic logic holds(input logic [3:0] s, input phase_t ph);
		return pool_phase[s] == ph && pool_leased[s];
	endfunction

	// Applies one request to the pool and returns its result.
	function automatic result_t serve_request(input request_t req);
		result_t r;
		logic [3:0] s;
		int nfree, nfill, nready;
		r = '0;
		r.status = ST_OK;
		s = req.slot;
		nfree = 0;
		nfill = 0;
		nready = 0;
		case (req.kind)
			K_TAKE_FREE: begin
				if (free_list.size() == 0) begin
					r.status = ST_NONE;
				end else begin
					r.granted_slot = free_list[0];
					free_list.delete(0);
					pool_phase[r.granted_slot] = PH_FILLING;
					pool_leased[r.granted_slot] = 1'b1;
					pool_bytes[r.granted_slot] = '0;
					r.payload_bytes = capacity;
				end
			end
			K_TAKE_READY: begin
				if (ready_list.size() == 0) begin
					r.status = ST_NONE;
				end else begin
					r.granted_slot = ready_list[0];
					ready_list.delete(0);
					pool_leased[r.granted_slot] = 1'b1;
					r.payload_bytes = pool_bytes[r.granted_slot];
				end
			end
			K_PUBLISH: begin
				if (!holds(s, PH_FILLING)) begin
					r.status = ST_WRONG;
				end else if (req.byte_count > capacity) begin
					r.status = ST_CAP;
				end else begin
					pool_bytes[s] = req.byte_count;
					pool_leased[s] = 1'b0;
					pool_phase[s] = PH_READY;
					ready_list.insert(ready_list.size(), s);
				end
			end
			K_CONSUME: begin
				if (!holds(s, PH_READY)) begin
					r.status = ST_WRONG;
				end else begin
					pool_bytes[s] = '0;
					pool_leased[s] = 1'b0;
					pool_phase[s] = PH_FREE;
					free_list.insert(free_list.size(), s);
				end
			end
			K_REL_FILL: begin
				if (!holds(s, PH_FILLING)) begin
					r.status = ST_RELEASE;
				end else begin
					pool_bytes[s] = '0;
					pool_leased[s] = 1'b0;
					pool_phase[s] = PH_FREE;
					free_list.insert(free_list.size(), s);
				end
			end
			K_REL_READY: begin
				if (!holds(s, PH_READY)) begin
					r.status = ST_RELEASE;
				end else begin
					pool_leased[s] = 1'b0;
					ready_list.insert(ready_list.size(), s);
				end
			end
			default: begin
				r.status = ST_RELEASE;
			end
		endcase
		for (int i = 0; i < POOL; i++) begin
			if (pool_phase[i] == PH_FREE)
				nfree++;
			else if (pool_phase[i] == PH_FILLING)
				nfill++;
			else
				nready++;
		end
		r.free_count = nfree[4:0];
		r.filling_count = nfill[4:0];
		r.ready_count = nready[4:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			capacity = CAP_RESET;
			free_list.delete();
			ready_list.delete();
			expected_results.delete();
			for (int i = 0; i < POOL; i++) begin
				pool_phase[i] = PH_FREE;
				pool_leased[i] = 1'b0;
				pool_bytes[i] = '0;
				free_list.insert(free_list.size(), i[3:0]);
			end
			mismatches = 0;
			results_checked = 0;
			pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					report($sformatf("result item with nothing outstanding, status %0d",
						result.status));
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					compare_field("status", 21'(result.status), 21'(want.status));
					compare_field("granted_slot", 21'(result.granted_slot),
						21'(want.granted_slot));
					compare_field("payload_bytes", result.payload_bytes,
						want.payload_bytes);
					compare_field("free_count", 21'(result.free_count),
						21'(want.free_count));
					compare_field("filling_count", 21'(result.filling_count),
						21'(want.filling_count));
					compare_field("ready_count", 21'(result.ready_count),
						21'(want.ready_count));
				end
			end
			if (request_valid && request_ready)
				expected_results.insert(expected_results.size(), serve_request(request));
			if (cfg_wr_en)
				capacity = cfg_wr_data;
			pending <= expected_results.size();
		end
	end

endmodule

/* test/tb_slot_pool_lease_manager.sv */
`timescale 1ns / 1ps

module tb_slot_pool_lease_manager;
	import splm_pkg::*;

	localparam logic [2:0] K_UNUSED_6 = 3'd6;
	localparam logic [2:0] K_UNUSED_7 = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int BYTE_MAX = 2097151;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [20:0] cfg_wr_data = '0;
	logic        request_valid = 1'b0;
	logic        request_ready;
	request_t    request = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;

	int mismatches;
	int pending;
	int results_checked;
	int cycles = 0;
	int items_sent = 0;
	int config_writes = 0;
	bit no_idle = 1'b0;
	bit long_hold = 1'b0;

	logic [20:0] cap_now = CAP_RESET;
	logic [3:0]  held_filling [$];
	logic [3:0]  held_ready [$];
	logic [2:0]  kinds_in_flight [$];

	slot_pool_lease_manager uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.request_valid (request_valid),
		.request_ready (request_ready),
		.request       (request),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result)
	);

	slot_pool_lease_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.request_valid   (request_valid),
		.request_ready   (request_ready),
		.request         (request),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result          (result),
		.mismatches      (mismatches),
		.pending         (pending),
		.results_checked (results_checked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_slot_pool_lease_manager failed");
			$finish;
		end
	end

	// track granted leases so later requests can target slots actually held
	always @(negedge clk) begin
		logic [2:0] k;
		if (arst_n) begin
			if (result_valid && result_ready && kinds_in_flight.size() > 0) begin
				k = kinds_in_flight[0];
				kinds_in_flight.delete(0);
				if (result.status == ST_OK) begin
					if (k == K_TAKE_FREE)
						held_filling.insert(held_filling.size(), result.granted_slot);
					else if (k == K_TAKE_READY)
						held_ready.insert(held_ready.size(), result.granted_slot);
				end
			end
			if (request_valid && request_ready) begin
				kinds_in_flight.insert(kinds_in_flight.size(), request.kind);
				items_sent++;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		int burst;
		int gap;
		bit hold_done;
		hold_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold && !hold_done) begin
				hold_done = 1'b1;
				result_ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else begin
				burst = $urandom_range(1, 12);
				result_ready <= 1'b1;
				repeat (burst) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					result_ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	task automatic send(input logic [2:0] k, input logic [3:0] s, input logic [20:0] b);
		request_t r;
		int gap;
		r.kind = k;
		r.slot = s;
		r.byte_count = b;
		gap = pick_gap();
		if (gap > 0) begin
			request_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		request_valid <= 1'b1;
		request <= r;
		do @(posedge clk); while (!request_ready);
	endtask

	task automatic settle();
		request_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [20:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cap_now = v;
		config_writes++;
	endtask

	// mostly well-formed lease traffic on held slots, some misuse and noise
	task automatic random_requests(input int count);
		int r;
		int rb;
		int idx;
		logic [2:0] k;
		logic [3:0] s;
		logic [20:0] b;
		repeat (count) begin
			r = $urandom_range(0, 99);
			s = 4'($urandom_range(0, 15));
			b = 21'($urandom_range(0, BYTE_MAX));
			if (r < 24) begin
				k = K_TAKE_FREE;
			end else if (r < 42) begin
				k = K_TAKE_READY;
			end else if (r < 62) begin
				k = K_PUBLISH;
				rb = $urandom_range(0, 99);
				if (rb < 10)
					b = cap_now;
				else if (rb < 16)
					b = '0;
				else if (rb < 24)
					b = 21'($urandom_range(cap_now + 1, BYTE_MAX));
				else
					b = 21'($urandom_range(0, cap_now));
				if (held_filling.size() > 0) begin
					idx = $urandom_range(0, held_filling.size() - 1);
					s = held_filling[idx];
					if (b <= cap_now)
						held_filling.delete(idx);
				end
			end else if (r < 76) begin
				k = K_CONSUME;
				if (held_ready.size() > 0) begin
					idx = $urandom_range(0, held_ready.size() - 1);
					s = held_ready[idx];
					held_ready.delete(idx);
				end
			end else if (r < 83) begin
				k = K_REL_FILL;
				if (held_filling.size() > 0) begin
					idx = $urandom_range(0, held_filling.size() - 1);
					s = held_filling[idx];
					held_filling.delete(idx);
				end
			end else if (r < 90) begin
				k = K_REL_READY;
				if (held_ready.size() > 0) begin
					idx = $urandom_range(0, held_ready.size() - 1);
					s = held_ready[idx];
					held_ready.delete(idx);
				end
			end else begin
				k = 3'($urandom_range(0, 7));
			end
			send(k, s, b);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(K_TAKE_READY, 4'd0, 21'd0);
		send(K_PUBLISH, 4'd0, 21'd0);
		send(K_CONSUME, 4'd15, 21'h1FFFFF);
		send(K_REL_FILL, 4'd3, 21'd0);
		send(K_REL_READY, 4'd0, 21'd0);
		send(K_UNUSED_6, 4'd5, 21'd77);
		send(K_UNUSED_7, 4'd10, 21'h155555);
		send(K_TAKE_FREE, 4'd0, 21'd0);
		send(K_PUBLISH, 4'd0, 21'd4097);
		send(K_PUBLISH, 4'd0, 21'd4096);
		send(K_CONSUME, 4'd0, 21'd0);
		send(K_REL_READY, 4'd0, 21'd0);
		send(K_TAKE_READY, 4'd0, 21'd0);
		send(K_PUBLISH, 4'd0, 21'd0);
		send(K_REL_READY, 4'd0, 21'd0);
		send(K_TAKE_READY, 4'd0, 21'd0);
		send(K_CONSUME, 4'd0, 21'd0);
		send(K_TAKE_FREE, 4'd0, 21'd0);
		send(K_REL_FILL, 4'd1, 21'd0);
		send(K_REL_FILL, 4'd1, 21'd0);
		settle();
		held_filling.delete();
		held_ready.delete();

		random_requests(250);
		no_idle = 1'b1;
		random_requests(100);
		no_idle = 1'b0;
		settle();
		random_requests(100);

		write_capacity(21'd1);
		repeat (17)
			send(K_TAKE_FREE, 4'($urandom_range(0, 15)), 21'($urandom_range(0, BYTE_MAX)));
		random_requests(150);

		write_capacity(21'd1048576);
		random_requests(100);
		long_hold = 1'b1;
		random_requests(100);
		random_requests(150);

		write_capacity(21'($urandom_range(2, 1048575)));
		random_requests(250);

		write_capacity(21'($urandom_range(1, 64)));
		random_requests(200);

		settle();
		$display("%0d request items, %0d results checked, %0d capacity writes",
			items_sent, results_checked, config_writes);
		$display("covered empty takes, lease misuse, capacity 1 to 1048576, long result stall");
		if (mismatches == 0 && pending == 0)
			$display("tb_slot_pool_lease_manager passed");
		else
			$display("tb_slot_pool_lease_manager failed");
		$finish;
	end

endmodule
